// ===== src/fcvs_pkg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// fcvs_pkg
// Shared types and codes for the fixed-capacity value set.
// ----------------------------------------------------------------------------
package fcvs_pkg;

  localparam int unsigned ValueW = 32;
  localparam int unsigned CountW = 7;

  // Request operation codes
  typedef enum logic [2:0] {
    FN_INSERT = 3'd0,
    FN_REMOVE = 3'd1,
    FN_QUERY  = 3'd2,
    FN_REWIND = 3'd3,
    FN_NEXT   = 3'd4
  } fcvs_func_e;

  // One stored slot: valid bit and value
  typedef struct packed {
    logic              vld;
    logic [ValueW-1:0] val;
  } slot_t;

endpackage
`default_nettype wire

// ===== src/fixed_capacity_value_set_top.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// fixed_capacity_value_set_top
// Set of up to CAPACITY signed 32-bit values held in a slot memory with a
// valid bit per slot; insert, remove, query, rewind and iterate.
//
//   channel  direction  signals
//   -------  ---------  ---------------------------------------------------
//   in       to block   in_valid_i, in_ready_o, func_i, key_i
//   out      from block out_valid_o, out_ready_i, ok_o, next_value_o,
//                       count_o, has_more_o
//
// An item scans the slot memory one slot per cycle. Insert, remove and
// query scan from slot 0 and stop at the first match; next scans from the
// walk position and stops at the first valid slot; rewind and unused codes
// skip the scan. Reset starts a clearing pass that writes every slot
// invalid, with in_ready_o low. An item is taken while a result waits, and
// its work stalls at the end until the output is free.
// ----------------------------------------------------------------------------
module fixed_capacity_value_set_top #(
  parameter int unsigned CAPACITY = 64
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        in_valid_i,
  output logic             in_ready_o,
  input  wire logic [2:0]  func_i,
  input  wire logic signed [31:0] key_i,
  output logic             out_valid_o,
  input  wire logic        out_ready_i,
  output logic             ok_o,
  output logic signed [31:0] next_value_o,
  output logic [6:0]       count_o,
  output logic             has_more_o
);
  import fcvs_pkg::*;

  localparam int unsigned AW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int unsigned CW = $clog2(CAPACITY + 1);
  localparam logic [CW-1:0] CapW = CW'(CAPACITY);
  localparam logic [CW-1:0] LastW = CW'(CAPACITY - 1);

  localparam logic [1:0] ST_CLEAR = 2'd0;
  localparam logic [1:0] ST_IDLE  = 2'd1;
  localparam logic [1:0] ST_SCAN  = 2'd2;
  localparam logic [1:0] ST_FIN   = 2'd3;

  logic [1:0]        state_q, state_d;
  fcvs_func_e        func_q, func_d;
  logic [ValueW-1:0] key_q, key_d;
  logic [CW-1:0]     addr_q, addr_d;
  logic [AW-1:0]     chk_q, chk_d;
  logic              chk_vld_q, chk_vld_d;
  logic              hit_q, hit_d;
  logic [AW-1:0]     hit_idx_q, hit_idx_d;
  logic              free_q, free_d;
  logic [AW-1:0]     free_idx_q, free_idx_d;
  logic [ValueW-1:0] fval_q, fval_d;
  logic [CW-1:0]     iter_q, iter_d;
  logic [CW-1:0]     cnt_q, cnt_d;
  logic              out_valid_q, out_valid_d;
  logic              ok_q, ok_d;
  logic [ValueW-1:0] val_q, val_d;

  logic              rd_en;
  slot_t             rd_data;
  logic              wr_en;
  logic [AW-1:0]     wr_addr;
  slot_t             wr_data;
  logic              in_fire;
  logic              fin_fire;
  logic [CW+6:0]     cnt_ext;

  fcvs_slot_ram #(
    .Depth (CAPACITY),
    .AddrW (AW)
  ) u_slot_ram (
    .clk_i     (clk_i),
    .rd_en_i   (rd_en),
    .rd_addr_i (addr_q[AW-1:0]),
    .rd_data_o (rd_data),
    .wr_en_i   (wr_en),
    .wr_addr_i (wr_addr),
    .wr_data_i (wr_data)
  );

  assign in_ready_o = (state_q == ST_IDLE);
  assign in_fire    = in_valid_i && in_ready_o;
  assign fin_fire   = (state_q == ST_FIN) && (!out_valid_q || out_ready_i);

  // Sequencer: clear pass, scan, finish with write-back
  always_comb begin
    state_d     = state_q;
    func_d      = func_q;
    key_d       = key_q;
    addr_d      = addr_q;
    chk_d       = chk_q;
    chk_vld_d   = 1'b0;
    hit_d       = hit_q;
    hit_idx_d   = hit_idx_q;
    free_d      = free_q;
    free_idx_d  = free_idx_q;
    fval_d      = fval_q;
    iter_d      = iter_q;
    cnt_d       = cnt_q;
    out_valid_d = out_valid_q && !out_ready_i;
    ok_d        = ok_q;
    val_d       = val_q;
    rd_en       = 1'b0;
    wr_en       = 1'b0;
    wr_addr     = addr_q[AW-1:0];
    wr_data     = '{vld: 1'b0, val: key_q};

    unique case (state_q)
      ST_CLEAR: begin
        // Write one slot invalid per cycle
        wr_en  = 1'b1;
        addr_d = addr_q + CW'(1);
        if (addr_q == LastW) begin
          state_d = ST_IDLE;
        end
      end

      ST_IDLE: begin
        if (in_fire) begin
          func_d    = fcvs_func_e'(func_i);
          key_d     = key_i;
          hit_d     = 1'b0;
          free_d    = 1'b0;
          addr_d    = (fcvs_func_e'(func_i) == FN_NEXT) ? iter_q : '0;
          unique case (fcvs_func_e'(func_i)) inside
            FN_INSERT, FN_REMOVE, FN_QUERY, FN_NEXT: state_d = ST_SCAN;
            default:                                 state_d = ST_FIN;
          endcase
        end
      end

      ST_SCAN: begin
        // Issue the next read
        if (addr_q < CapW) begin
          rd_en     = 1'b1;
          chk_vld_d = 1'b1;
          chk_d     = addr_q[AW-1:0];
          addr_d    = addr_q + CW'(1);
        end
        // Check the slot read last cycle
        if (chk_vld_q) begin
          if (func_q == FN_NEXT) begin
            if (rd_data.vld) begin
              hit_d     = 1'b1;
              hit_idx_d = chk_q;
              fval_d    = rd_data.val;
              state_d   = ST_FIN;
            end
          end else begin
            if (rd_data.vld && (rd_data.val == key_q)) begin
              hit_d     = 1'b1;
              hit_idx_d = chk_q;
              state_d   = ST_FIN;
            end
            if (!rd_data.vld && !free_q) begin
              free_d     = 1'b1;
              free_idx_d = chk_q;
            end
          end
        end else if (addr_q == CapW) begin
          state_d = ST_FIN;
        end
      end

      ST_FIN: begin
        if (fin_fire) begin
          state_d     = ST_IDLE;
          out_valid_d = 1'b1;
          ok_d        = 1'b0;
          val_d       = '1;
          unique case (func_q)
            FN_INSERT: begin
              if (!hit_q && free_q) begin
                wr_en   = 1'b1;
                wr_addr = free_idx_q;
                wr_data = '{vld: 1'b1, val: key_q};
                cnt_d   = cnt_q + CW'(1);
                ok_d    = 1'b1;
              end
            end
            FN_REMOVE: begin
              if (hit_q) begin
                wr_en   = 1'b1;
                wr_addr = hit_idx_q;
                cnt_d   = cnt_q - CW'(1);
                ok_d    = 1'b1;
              end
            end
            FN_QUERY: begin
              ok_d = hit_q;
            end
            FN_REWIND: begin
              iter_d = '0;
            end
            FN_NEXT: begin
              if (hit_q) begin
                ok_d   = 1'b1;
                val_d  = fval_q;
                iter_d = CW'(hit_idx_q) + CW'(1);
              end else begin
                iter_d = CapW;
              end
            end
            default: begin
              // unused codes: no change
            end
          endcase
        end
      end

      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  // Control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_CLEAR;
      addr_q      <= '0;
      chk_vld_q   <= 1'b0;
      hit_q       <= 1'b0;
      free_q      <= 1'b0;
      iter_q      <= '0;
      cnt_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      addr_q      <= addr_d;
      chk_vld_q   <= chk_vld_d;
      hit_q       <= hit_d;
      free_q      <= free_d;
      iter_q      <= iter_d;
      cnt_q       <= cnt_d;
      out_valid_q <= out_valid_d;
    end
  end

  // Payload registers
  always_ff @(posedge clk_i) begin
    func_q     <= func_d;
    key_q      <= key_d;
    chk_q      <= chk_d;
    hit_idx_q  <= hit_idx_d;
    free_idx_q <= free_idx_d;
    fval_q     <= fval_d;
    ok_q       <= ok_d;
    val_q      <= val_d;
  end

  // Count and position only change when a result is loaded, so they
  // hold steady while that result waits
  assign cnt_ext      = (CW + 7)'(cnt_q);
  assign out_valid_o  = out_valid_q;
  assign ok_o         = ok_q;
  assign next_value_o = val_q;
  assign count_o      = cnt_ext[CountW-1:0];
  assign has_more_o   = (iter_q < CapW);

endmodule
`default_nettype wire

// ===== src/fcvs_slot_ram.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// fcvs_slot_ram
// Slot store: one write port, one read port with registered read data.
// ----------------------------------------------------------------------------
module fcvs_slot_ram #(
  parameter int unsigned Depth = 64,
  parameter int unsigned AddrW = 6
) (
  input  wire logic             clk_i,
  input  wire logic             rd_en_i,
  input  wire logic [AddrW-1:0] rd_addr_i,
  output fcvs_pkg::slot_t       rd_data_o,
  input  wire logic             wr_en_i,
  input  wire logic [AddrW-1:0] wr_addr_i,
  input  wire fcvs_pkg::slot_t  wr_data_i
);
  import fcvs_pkg::*;

  slot_t mem [Depth];
  slot_t rd_data_q;

  // Write one slot
  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem[wr_addr_i] <= wr_data_i;
    end
  end

  // Read one slot, data valid next cycle
  always_ff @(posedge clk_i) begin
    if (rd_en_i) begin
      rd_data_q <= mem[rd_addr_i];
    end
  end

  assign rd_data_o = rd_data_q;

endmodule
`default_nettype wire

// ===== sim/fixed_capacity_value_set_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fixed_capacity_value_set_checker
// Watches both channels of the value set. It keeps its own copy of the slots,
// the walk position and the live count. For each item taken in it predicts
// the result, and it compares every result leaving the block, field by field,
// with the oldest prediction.
// ----------------------------------------------------------------------------
module fixed_capacity_value_set_checker #(
  parameter int unsigned CAPACITY = 64
) (
  input  wire logic                        clk_i,
  input  wire logic                        rst_ni,
  input  wire logic                        in_valid_i,
  input  wire logic                        in_ready_i,
  input  wire logic [2:0]                  func_i,
  input  wire logic [fcvs_pkg::ValueW-1:0] key_i,
  input  wire logic                        out_valid_i,
  input  wire logic                        out_ready_i,
  input  wire logic                        ok_i,
  input  wire logic [fcvs_pkg::ValueW-1:0] next_value_i,
  input  wire logic [fcvs_pkg::CountW-1:0] count_i,
  input  wire logic                        has_more_i,
  output int unsigned                      err_cnt_o,
  output int unsigned                      pending_o,
  output int unsigned                      checked_o
);
  import fcvs_pkg::*;

  typedef struct packed {
    logic              ok;
    logic [ValueW-1:0] next_value;
    logic [CountW-1:0] count;
    logic              has_more;
  } set_result_t;

  logic              held_vld [CAPACITY];
  logic [ValueW-1:0] held_val [CAPACITY];
  int unsigned       walk_pos;
  int unsigned       live_cnt;
  set_result_t       due_q [$];
  int unsigned       miss_cnt;
  int unsigned       due_cnt;
  int unsigned       done_cnt;

  assign err_cnt_o = miss_cnt;
  assign pending_o = due_cnt;
  assign checked_o = done_cnt;

  // Lowest valid slot holding the key, CAPACITY when absent
  function automatic int unsigned lookup_slot(input logic [ValueW-1:0] key);
    for (int unsigned i = 0; i < CAPACITY; i++) begin
      if (held_vld[i] && held_val[i] == key) return i;
    end
    return CAPACITY;
  endfunction

  // Apply one request to the slot copy and build its result
  task automatic apply_request(input logic [2:0] func, input logic [ValueW-1:0] key,
                               output set_result_t res);
    int unsigned hit;
    int unsigned nxt;
    res.ok         = 1'b0;
    res.next_value = '1;
    hit            = lookup_slot(key);
    case (func)
      FN_INSERT: begin
        if (hit == CAPACITY) begin
          for (int unsigned i = 0; i < CAPACITY; i++) begin
            if (!held_vld[i]) begin
              held_vld[i] = 1'b1;
              held_val[i] = key;
              live_cnt++;
              res.ok = 1'b1;
              break;
            end
          end
        end
      end
      FN_REMOVE: begin
        if (hit < CAPACITY) begin
          held_vld[hit] = 1'b0;
          live_cnt--;
          res.ok = 1'b1;
        end
      end
      FN_QUERY: begin
        res.ok = (hit < CAPACITY);
      end
      FN_REWIND: begin
        walk_pos = 0;
      end
      FN_NEXT: begin
        // saturate at CAPACITY when nothing is left
        nxt = CAPACITY;
        for (int unsigned i = walk_pos; i < CAPACITY; i++) begin
          if (held_vld[i]) begin
            res.next_value = held_val[i];
            res.ok         = 1'b1;
            nxt            = i + 1;
            break;
          end
        end
        walk_pos = nxt;
      end
      default: begin
      end
    endcase
    res.count    = CountW'(live_cnt);
    res.has_more = (walk_pos < CAPACITY);
  endtask

  task automatic check_field(input string name, input logic [ValueW-1:0] want,
                             input logic [ValueW-1:0] got);
    if (want !== got) begin
      $error("%s: expected 0x%0h, actual 0x%0h", name, want, got);
      miss_cnt++;
    end
  endtask

  // Retire results first: a result leaving now never belongs to the item
  // taken in at the same edge
  always @(posedge clk_i or negedge rst_ni) begin
    set_result_t want;
    set_result_t got;
    if (!rst_ni) begin
      for (int unsigned i = 0; i < CAPACITY; i++) held_vld[i] = 1'b0;
      walk_pos = 0;
      live_cnt = 0;
      due_q.delete();
      miss_cnt = 0;
      due_cnt  = 0;
      done_cnt = 0;
    end else begin
      if (out_valid_i && out_ready_i) begin
        got.ok         = ok_i;
        got.next_value = next_value_i;
        got.count      = count_i;
        got.has_more   = has_more_i;
        if (due_q.size() == 0) begin
          $error("result with no item waiting: ok %0b next_value 0x%0h count %0d has_more %0b",
                 got.ok, got.next_value, got.count, got.has_more);
          miss_cnt++;
        end else begin
          want = due_q.pop_front();
          check_field("ok", ValueW'(want.ok), ValueW'(got.ok));
          check_field("next_value", want.next_value, got.next_value);
          check_field("count", ValueW'(want.count), ValueW'(got.count));
          check_field("has_more", ValueW'(want.has_more), ValueW'(got.has_more));
          done_cnt++;
        end
      end
      if (in_valid_i && in_ready_i) begin
        apply_request(func_i, key_i, want);
        due_q.push_back(want);
      end
      due_cnt = due_q.size();
    end
  end

endmodule

// ===== sim/fixed_capacity_value_set_top_tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fixed_capacity_value_set_top_tb
// Drives the value set with a short directed opening, then random bursts that
// fill, drain, walk and mix the set, with random idling on both channels and
// long receiver hold-offs. The checker beside the block predicts and compares.
// ----------------------------------------------------------------------------
module fixed_capacity_value_set_top_tb;
  import fcvs_pkg::*;

  localparam int unsigned Capacity      = 64;
  localparam int unsigned ClkHalf       = 4;
  localparam int unsigned ResetCycles   = 8;
  localparam int unsigned ItemTarget    = 1400;
  localparam int unsigned HoldOffCycles = 400;
  localparam int unsigned StallLimit    = 4000;
  localparam int unsigned TailCycles    = Capacity + 16;
  localparam int unsigned PoolDepth     = 96;
  localparam logic [2:0]  FnSpareLo     = 3'd5;
  localparam logic [2:0]  FnSpareHi     = 3'd7;
  localparam logic [31:0] KeyMin        = 32'h8000_0000;
  localparam logic [31:0] KeyMax        = 32'h7fff_ffff;
  localparam logic [31:0] KeyAllOnes    = 32'hffff_ffff;

  typedef enum logic [1:0] {
    MODE_FILL,
    MODE_DRAIN,
    MODE_WALK,
    MODE_MIX
  } burst_mode_e;

  logic        clk        = 1'b0;
  logic        rst_n      = 1'b0;
  logic        in_valid   = 1'b0;
  logic        in_ready;
  logic [2:0]  func       = '0;
  logic [31:0] key        = '0;
  logic        out_valid;
  logic        out_ready  = 1'b0;
  logic        ok;
  logic [31:0] next_value;
  logic [6:0]  count;
  logic        has_more;

  int unsigned err_cnt;
  int unsigned pending;
  int unsigned checked;

  int unsigned op_cnt [8];
  int unsigned items_sent   = 0;
  int unsigned rx_taken     = 0;
  int unsigned stall_cycles = 0;
  int unsigned max_count    = 0;
  logic [31:0] key_pool [PoolDepth];
  int unsigned pool_fill    = 0;
  int unsigned pool_wr      = 0;
  bit          tx_fast      = 1'b0;
  bit          rx_fast      = 1'b0;

  fixed_capacity_value_set_top #(
    .CAPACITY(Capacity)
  ) dut (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .in_valid_i  (in_valid),
    .in_ready_o  (in_ready),
    .func_i      (func),
    .key_i       (key),
    .out_valid_o (out_valid),
    .out_ready_i (out_ready),
    .ok_o        (ok),
    .next_value_o(next_value),
    .count_o     (count),
    .has_more_o  (has_more)
  );

  fixed_capacity_value_set_checker #(
    .CAPACITY(Capacity)
  ) u_checker (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .in_valid_i  (in_valid),
    .in_ready_i  (in_ready),
    .func_i      (func),
    .key_i       (key),
    .out_valid_i (out_valid),
    .out_ready_i (out_ready),
    .ok_i        (ok),
    .next_value_i(next_value),
    .count_i     (count),
    .has_more_i  (has_more),
    .err_cnt_o   (err_cnt),
    .pending_o   (pending),
    .checked_o   (checked)
  );

  always #(ClkHalf) clk = ~clk;

  // Offer one item after a random gap and hold it until taken
  task automatic send_item(input logic [2:0] f, input logic [31:0] k);
    int unsigned gap;
    gap = tx_fast ? 0 : $urandom_range(0, 4);
    @(negedge clk);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    func     <= f;
    key      <= k;
    in_valid <= 1'b1;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    op_cnt[f]++;
    items_sent++;
  endtask

  // Pick a fresh key (remembered for later) or one used before
  task automatic choose_key(input burst_mode_e mode, output logic [31:0] k);
    int unsigned fresh_pct;
    case (mode)
      MODE_FILL:  fresh_pct = 75;
      MODE_DRAIN: fresh_pct = 10;
      MODE_WALK:  fresh_pct = 30;
      default:    fresh_pct = 50;
    endcase
    if (pool_fill == 0 || $urandom_range(0, 99) < fresh_pct) begin
      case ($urandom_range(0, 15))
        0:       k = KeyMin;
        1:       k = KeyMax;
        2:       k = '0;
        3:       k = KeyAllOnes;
        default: k = $urandom;
      endcase
      key_pool[pool_wr] = k;
      pool_wr = (pool_wr + 1) % PoolDepth;
      if (pool_fill < PoolDepth) pool_fill++;
    end else begin
      k = key_pool[$urandom_range(0, pool_fill - 1)];
    end
  endtask

  // Operation mix per burst mode
  task automatic choose_func(input burst_mode_e mode, output logic [2:0] f);
    int unsigned roll;
    roll = $urandom_range(0, 99);
    case (mode)
      MODE_FILL: begin
        if (roll < 85)      f = FN_INSERT;
        else if (roll < 95) f = FN_QUERY;
        else if (roll < 98) f = FN_NEXT;
        else                f = FN_REMOVE;
      end
      MODE_DRAIN: begin
        if (roll < 75)      f = FN_REMOVE;
        else if (roll < 85) f = FN_QUERY;
        else if (roll < 95) f = FN_NEXT;
        else                f = FN_INSERT;
      end
      MODE_WALK: begin
        if (roll < 80)      f = FN_NEXT;
        else if (roll < 88) f = FN_INSERT;
        else if (roll < 96) f = FN_REMOVE;
        else                f = FN_REWIND;
      end
      default: begin
        if (roll < 90) f = 3'($urandom_range(FN_INSERT, FN_NEXT));
        else           f = 3'($urandom_range(FnSpareLo, FnSpareHi));
      end
    endcase
  endtask

  // Receiver: random stall per result, two long hold-offs to back up the block
  initial begin
    int unsigned wait_n;
    @(posedge rst_n);
    forever begin
      @(negedge clk);
      if (rx_taken % 48 == 0) rx_fast = ($urandom_range(0, 3) == 0);
      if (rx_taken == 300 || rx_taken == 900) wait_n = HoldOffCycles;
      else if (rx_fast)                       wait_n = 0;
      else                                    wait_n = $urandom_range(0, 4);
      if (wait_n > 0) begin
        out_ready <= 1'b0;
        repeat (wait_n) @(negedge clk);
      end
      out_ready <= 1'b1;
      @(posedge clk);
      while (!out_valid) @(posedge clk);
      rx_taken++;
    end
  end

  // Watchdog on cycles with no item moving on either channel
  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready)) stall_cycles <= 0;
    else stall_cycles <= stall_cycles + 1;
    if (out_valid && out_ready && 32'(count) > max_count) max_count <= 32'(count);
    if (stall_cycles >= StallLimit) begin
      $display("fixed_capacity_value_set_top regression: fail");
      $finish;
    end
  end

  // Stimulus and verdict
  initial begin
    burst_mode_e mode;
    int unsigned burst_len;
    logic [2:0]  f;
    logic [31:0] k;

    repeat (ResetCycles) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // Empty set: query, next past the end, remove of an absent key
    send_item(FN_QUERY, '0);
    send_item(FN_NEXT, KeyAllOnes);
    send_item(FN_REMOVE, 32'd12345);
    send_item(FN_REWIND, '0);
    // Extreme keys, then a duplicate insert
    send_item(FN_INSERT, KeyMin);
    send_item(FN_INSERT, KeyMax);
    send_item(FN_INSERT, '0);
    send_item(FN_INSERT, KeyAllOnes);
    send_item(FN_INSERT, KeyMax);
    send_item(FN_QUERY, KeyAllOnes);
    send_item(FN_QUERY, 32'd1);
    // Free a middle slot and refill it
    send_item(FN_REMOVE, '0);
    send_item(FN_INSERT, 32'h5a5a_a5a5);
    // Walk to the end and past it, then rewind
    repeat (6) send_item(FN_NEXT, '0);
    send_item(FN_REWIND, KeyAllOnes);
    send_item(FN_NEXT, KeyMin);
    // Spare codes do nothing
    send_item(FnSpareLo, KeyMax);
    send_item(FnSpareHi, KeyAllOnes);
    send_item(FN_REMOVE, KeyMin);
    send_item(FN_QUERY, KeyMin);

    // Random bursts, each shaped toward one kind of work
    while (items_sent < ItemTarget) begin
      case ($urandom_range(0, 19)) inside
        [0:3]:    mode = MODE_FILL;
        [4:10]:   mode = MODE_DRAIN;
        [11:14]:  mode = MODE_WALK;
        default:  mode = MODE_MIX;
      endcase
      burst_len = $urandom_range(16, 96);
      tx_fast   = ($urandom_range(0, 3) == 0);
      if (mode == MODE_WALK) send_item(FN_REWIND, $urandom);
      for (int unsigned n = 0; n < burst_len && items_sent < ItemTarget; n++) begin
        choose_func(mode, f);
        choose_key(mode, k);
        send_item(f, k);
      end
    end

    // Drain and let the block settle
    @(negedge clk);
    in_valid <= 1'b0;
    while (pending != 0) @(negedge clk);
    repeat (TailCycles) @(negedge clk);

    $display("covered %0d items: %0d insert, %0d remove, %0d query, %0d rewind,",
             items_sent, op_cnt[FN_INSERT], op_cnt[FN_REMOVE], op_cnt[FN_QUERY],
             op_cnt[FN_REWIND]);
    $display("  %0d next, %0d spare; %0d results compared, set size peaked at %0d of %0d",
             op_cnt[FN_NEXT],
             op_cnt[FnSpareLo] + op_cnt[FnSpareLo + 3'd1] + op_cnt[FnSpareHi],
             checked, max_count, Capacity);
    if (err_cnt == 0) begin
      $display("fixed_capacity_value_set_top regression: pass");
    end else begin
      $display("fixed_capacity_value_set_top regression: fail");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
src/fcvs_pkg.sv
src/fcvs_slot_ram.sv
src/fixed_capacity_value_set_top.sv
sim/fixed_capacity_value_set_checker.sv
sim/fixed_capacity_value_set_top_tb.sv
